// ===== rtl/core/bsh_pkg.sv =====
`default_nettype none
package bsh_pkg;

  // Field widths
  localparam int POS_W     = 32;
  localparam int Q_W       = 16;
  localparam int LEN_W     = 31;
  localparam int IDX_W     = 3;

  // Q2.14 unity and Q.28 rotation scale
  localparam int QUAT_ONE  = 16384;
  localparam int ROT_SHIFT = 28;

  // Square root: one result bit per stage over a 64-bit radicand
  localparam int SQ_IN_W    = 64;
  localparam int SQRT_STEPS = SQ_IN_W / 2;
  localparam int REM_W      = SQRT_STEPS + 2;

  // Pipeline: five front stages, the root steps, one output stage
  localparam int FRONT_ST  = 5;
  localparam int BSH_DEPTH = FRONT_ST + SQRT_STEPS + 1;

  typedef struct packed {
    logic signed [POS_W-1:0] bottom_center_z;
    logic signed [Q_W-1:0]   quat_w;
    logic signed [Q_W-1:0]   quat_x;
    logic signed [Q_W-1:0]   quat_y;
    logic signed [Q_W-1:0]   quat_z;
    logic [LEN_W-1:0]        bottom_len_x;
    logic [LEN_W-1:0]        bottom_len_y;
    logic [LEN_W-1:0]        bottom_len_z;
    logic [LEN_W-1:0]        upper_len_x;
    logic [LEN_W-1:0]        upper_len_y;
    logic [LEN_W-1:0]        upper_len_z;
  } bsh_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] stack_height;
    logic [IDX_W-1:0]        top_corner_index;
    logic signed [POS_W-1:0] top_corner_height;
  } bsh_out_t;

  // Clamp a quaternion component to [-1.0, +1.0]
  function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
    logic signed [Q_W-1:0] hi;
    logic signed [Q_W-1:0] lo;
    hi = Q_W'(QUAT_ONE);
    lo = -hi;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Saturate a 38-bit signed value to 32 bits
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [37:0] v);
    logic signed [37:0] mx;
    logic signed [37:0] mn;
    mx = 38'sh0_7FFF_FFFF;
    mn = -mx - 38'sd1;
    if (v > mx) return mx[POS_W-1:0];
    if (v < mn) return mn[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bsh_if.sv =====
`default_nettype none
interface bsh_in_if;
  logic             valid;
  logic             ready;
  bsh_pkg::bsh_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsh_out_if;
  logic              valid;
  logic              ready;
  bsh_pkg::bsh_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bsh_sqrt_step.sv =====
`default_nettype none
module bsh_sqrt_step (
  input  wire logic [bsh_pkg::REM_W-1:0]      rem_i,
  input  wire logic [bsh_pkg::SQRT_STEPS-1:0] root_i,
  input  wire logic [1:0]                     pair_i,
  output logic      [bsh_pkg::REM_W-1:0]      rem_o,
  output logic      [bsh_pkg::SQRT_STEPS-1:0] root_o
);
  import bsh_pkg::*;

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             ge;

  // Restoring digit step: try 4*root+1 against the shifted remainder
  always_comb begin
    rem2  = {rem_i, pair_i};
    trial = {2'b00, root_i, 2'b01};
    ge    = (rem2 >= trial);
    rem_o = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
    root_o = {root_i[SQRT_STEPS-2:0], ge};
  end

endmodule
`default_nettype wire

// ===== rtl/core/box_stack_height.sv =====
// Channel | Dir | Payload                                  | Handshake
// in_ch   | in  | center z, quaternion, bottom/upper sides  | valid/ready
// out_ch  | out | stack height, top corner index and height | valid/ready
//
// One word per cycle in and out unless out_ch stalls; stages: five arithmetic
// stages, 32 square-root digit stages (one root bit each), one output stage.
// The root pipeline of the upper diagonal sets the latency.
// rst_n (synchronous) clears only the stage valid bits.
// A stage holds while it and every stage after it is full and out_ch stalls;
// empty stages let earlier words move up.
`default_nettype none
module box_stack_height (
  input wire logic  clk,
  input wire logic  rst_n,
  bsh_in_if.sink    in_ch,
  bsh_out_if.source out_ch
);
  import bsh_pkg::*;

  logic [BSH_DEPTH-1:0] vld_r;
  logic [BSH_DEPTH-1:0] en;

  // Stage enables: a stage moves when out_ch is ready or it or any later stage has room
  genvar g;
  generate
    for (g = 0; g < BSH_DEPTH; g++) begin : g_en
      assign en[g] = out_ch.ready | ~(&vld_r[BSH_DEPTH-1:g]);
    end
  endgenerate

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < BSH_DEPTH; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // S1: clamp, quaternion products, upper side squares
  logic signed [Q_W-1:0] qw, qx, qy, qz;
  logic signed [29:0] p_xz_r, p_wy_r, p_yz_r, p_wx_r, p_xx_r, p_yy_r;
  logic signed [29:0] p_xz_nxt, p_wy_nxt, p_yz_nxt, p_wx_nxt, p_xx_nxt, p_yy_nxt;
  logic [61:0] sqx_r, sqy_r, sqz_r, sqx_nxt, sqy_nxt, sqz_nxt;
  logic signed [POS_W-1:0] cz1_r;
  logic [LEN_W-1:0] lx1_r, ly1_r, lz1_r;

  always_comb begin
    qw = clamp_q(in_ch.data.quat_w);
    qx = clamp_q(in_ch.data.quat_x);
    qy = clamp_q(in_ch.data.quat_y);
    qz = clamp_q(in_ch.data.quat_z);
    p_xz_nxt = qx * qz;
    p_wy_nxt = qw * qy;
    p_yz_nxt = qy * qz;
    p_wx_nxt = qw * qx;
    p_xx_nxt = qx * qx;
    p_yy_nxt = qy * qy;
    sqx_nxt = in_ch.data.upper_len_x * in_ch.data.upper_len_x;
    sqy_nxt = in_ch.data.upper_len_y * in_ch.data.upper_len_y;
    sqz_nxt = in_ch.data.upper_len_z * in_ch.data.upper_len_z;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_xz_r <= p_xz_nxt;
      p_wy_r <= p_wy_nxt;
      p_yz_r <= p_yz_nxt;
      p_wx_r <= p_wx_nxt;
      p_xx_r <= p_xx_nxt;
      p_yy_r <= p_yy_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      sqz_r  <= sqz_nxt;
      cz1_r  <= in_ch.data.bottom_center_z;
      lx1_r  <= in_ch.data.bottom_len_x;
      ly1_r  <= in_ch.data.bottom_len_y;
      lz1_r  <= in_ch.data.bottom_len_z;
    end
  end

  // S2: half rotation row in Q.28, sum of squares
  logic signed [30:0] h20_r, h21_r, h22_r, h20_nxt, h21_nxt, h22_nxt;
  logic [SQ_IN_W-1:0] ssq2_r, ssq2_nxt;
  logic signed [POS_W-1:0] cz2_r;
  logic [LEN_W-1:0] lx2_r, ly2_r, lz2_r;

  always_comb begin
    h20_nxt  = p_xz_r - p_wy_r;
    h21_nxt  = p_yz_r + p_wx_r;
    h22_nxt  = 31'sd134217728 - p_xx_r - p_yy_r;
    ssq2_nxt = SQ_IN_W'(sqx_r) + SQ_IN_W'(sqy_r) + SQ_IN_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h20_r <= h20_nxt;
      h21_r <= h21_nxt;
      h22_r <= h22_nxt;
      ssq2_r <= ssq2_nxt;
      cz2_r <= cz1_r;
      lx2_r <= lx1_r;
      ly2_r <= ly1_r;
      lz2_r <= lz1_r;
    end
  end

  // S3: offset terms, half rotation entry times full side (= entry * half side)
  logic signed [61:0] tx_r, ty_r, tz_r, tx_nxt, ty_nxt, tz_nxt;
  logic [SQ_IN_W-1:0] ssq3_r;
  logic signed [POS_W-1:0] cz3_r;

  always_comb begin
    tx_nxt = h20_r * $signed({1'b0, lx2_r});
    ty_nxt = h21_r * $signed({1'b0, ly2_r});
    tz_nxt = h22_r * $signed({1'b0, lz2_r});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      tz_r <= tz_nxt;
      ssq3_r <= ssq2_r;
      cz3_r <= cz2_r;
    end
  end

  // S4: highest corner flips every negative term; zero terms keep the
  // plus sign so the lowest index wins ties
  logic [61:0] atx, aty, atz;
  logic [62:0] best_r, best_nxt;
  logic [IDX_W-1:0] idx4_r, idx4_nxt;
  logic [SQ_IN_W-1:0] ssq4_r;
  logic signed [POS_W-1:0] cz4_r;

  always_comb begin
    atx = tx_r[61] ? 62'(-tx_r) : 62'(tx_r);
    aty = ty_r[61] ? 62'(-ty_r) : 62'(ty_r);
    atz = tz_r[61] ? 62'(-tz_r) : 62'(tz_r);
    best_nxt = 63'(atx) + 63'(aty) + 63'(atz);
    idx4_nxt = {tx_r[61], ty_r[61], tz_r[61]};
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      best_r <= best_nxt;
      idx4_r <= idx4_nxt;
      ssq4_r <= ssq3_r;
      cz4_r  <= cz3_r;
    end
  end

  // S5: round offset to position scale, add center
  logic [62:0] rnd_sum;
  logic signed [36:0] crn5_r, crn5_nxt;
  logic [IDX_W-1:0] idx5_r;
  logic [SQ_IN_W-1:0] ssq5_r;

  always_comb begin
    rnd_sum  = best_r + (63'd1 << (ROT_SHIFT - 1));
    crn5_nxt = cz4_r + $signed({2'b00, rnd_sum[62:ROT_SHIFT]});
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      crn5_r <= crn5_nxt;
      idx5_r <= idx4_r;
      ssq5_r <= ssq4_r;
    end
  end

  // Square root stages, one root bit each
  logic [SQ_IN_W-1:0]    sq_n_r   [SQRT_STEPS];
  logic [REM_W-1:0]      sq_rem_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_root_r[SQRT_STEPS];
  logic signed [36:0]    sq_crn_r [SQRT_STEPS];
  logic [IDX_W-1:0]      sq_idx_r [SQRT_STEPS];

  generate
    for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      logic [SQ_IN_W-1:0]    n_in;
      logic [REM_W-1:0]      rem_in, rem_nxt;
      logic [SQRT_STEPS-1:0] root_in, root_nxt;
      logic signed [36:0]    crn_in;
      logic [IDX_W-1:0]      idx_in;

      if (g == 0) begin : g_first
        assign n_in    = ssq5_r;
        assign rem_in  = '0;
        assign root_in = '0;
        assign crn_in  = crn5_r;
        assign idx_in  = idx5_r;
      end else begin : g_next
        assign n_in    = sq_n_r[g-1];
        assign rem_in  = sq_rem_r[g-1];
        assign root_in = sq_root_r[g-1];
        assign crn_in  = sq_crn_r[g-1];
        assign idx_in  = sq_idx_r[g-1];
      end

      bsh_sqrt_step u_step (
        .rem_i  (rem_in),
        .root_i (root_in),
        .pair_i (n_in[SQ_IN_W-1-2*g -: 2]),
        .rem_o  (rem_nxt),
        .root_o (root_nxt)
      );

      always_ff @(posedge clk) begin
        if (en[FRONT_ST+g]) begin
          sq_n_r[g]    <= n_in;
          sq_rem_r[g]  <= rem_nxt;
          sq_root_r[g] <= root_nxt;
          sq_crn_r[g]  <= crn_in;
          sq_idx_r[g]  <= idx_in;
        end
      end
    end
  endgenerate

  // Output stage: rounded half diagonal, saturation
  logic [SQRT_STEPS:0]     root_p1;
  logic signed [37:0]      stack;
  logic signed [36:0]      crn_l;
  bsh_out_t                out_r, out_nxt;

  always_comb begin
    crn_l   = sq_crn_r[SQRT_STEPS-1];
    root_p1 = {1'b0, sq_root_r[SQRT_STEPS-1]} + 1'b1;
    stack   = crn_l + $signed({6'b0, root_p1[SQRT_STEPS:1]});
    out_nxt.stack_height      = sat32(stack);
    out_nxt.top_corner_index  = sq_idx_r[SQRT_STEPS-1];
    out_nxt.top_corner_height = sat32({crn_l[36], crn_l});
  end

  always_ff @(posedge clk) begin
    if (en[BSH_DEPTH-1]) out_r <= out_nxt;
  end

  assign out_ch.valid = vld_r[BSH_DEPTH-1];
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/bsh_checker.sv =====
`default_nettype none
module bsh_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [31:0]        out_stack,
  input wire logic signed [31:0]        out_corner
);
  import bsh_pkg::*;

  logic [6:0] cnt_r;
  logic [6:0] cnt_nxt;

  // Words accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r + 7'(in_valid & in_ready) - 7'(out_valid & out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stack))
    else $error("result word dropped or changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 7'd0)
    else $error("result word without an accepted input");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 7'(BSH_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_stack_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stack >= out_corner)
    else $error("stack height below top corner");

endmodule

bind box_stack_height bsh_checker u_bsh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_stack  (out_ch.data.stack_height),
  .out_corner (out_ch.data.top_corner_height)
);
`default_nettype wire
